// ===== rtl/pmt_pkg.sv =====
// Shared types and constants for the pending message tracker.
package pmt_pkg;

	localparam int unsigned DEPTH_DEF     = 16;
	localparam int unsigned ID_W          = 32;
	localparam int unsigned TIME_W        = 32;
	localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd600000;

	typedef enum logic {
		REQ_RECORD   = 1'b0,
		REQ_RESPONSE = 1'b1
	} req_type_t;

	typedef enum logic [2:0] {
		ST_COMPLETED = 3'd0,
		ST_EXPIRED   = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_RECORDED  = 3'd3,
		ST_FULL      = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FINISH
	} state_t;

	typedef struct packed {
		req_type_t         req_type;
		logic [ID_W-1:0]   msg_id;
		logic [TIME_W-1:0] time_ms;
	} req_t;

	typedef struct packed {
		status_t         status;
		logic [ID_W-1:0] out_id;
		logic            last;
	} result_t;

	typedef struct packed {
		logic load;
		logic shift;
	} cell_ctrl_t;

endpackage

// ===== rtl/pmt_cell.sv =====
// One storage cell of the entry chain: holds an id and a send time.
module pmt_cell (
	input  logic                      clk,
	input  pmt_pkg::cell_ctrl_t       ctl,
	input  logic [pmt_pkg::ID_W-1:0]  load_id,
	input  logic [pmt_pkg::TIME_W-1:0] load_tstamp,
	input  logic [pmt_pkg::ID_W-1:0]  nbr_id,
	input  logic [pmt_pkg::TIME_W-1:0] nbr_tstamp,
	output logic [pmt_pkg::ID_W-1:0]  id,
	output logic [pmt_pkg::TIME_W-1:0] tstamp
);
	import pmt_pkg::*;

	logic [ID_W-1:0]   id_q;
	logic [TIME_W-1:0] tstamp_q;

	// load wins over shift: the rotated front entry lands at the tail
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			id_q     <= load_id;
			tstamp_q <= load_tstamp;
		end else if (ctl.shift) begin
			id_q     <= nbr_id;
			tstamp_q <= nbr_tstamp;
		end
	end

	assign id     = id_q;
	assign tstamp = tstamp_q;

endmodule

// ===== rtl/pending_message_tracker.sv =====
// Top level of the pending message tracker: cell chain and scan sequencer.
//
// Usage: present a request on req and raise start; it is taken at a rising
// edge with start high and busy low. A record request (req_type 0) appends
// an entry to the back of the queue, or reports full; its single result
// appears on result with result_valid high in the next cycle, and busy
// stays low, so records may follow one per cycle.
// A response request (req_type 1) raises busy and scans the queue from the
// front, one entry per cycle through cell 0 of the chain: a match
// completes and ends the scan, an aged entry is expired, others rotate to
// the back. Each result is shown for exactly one cycle with result_valid.
// A response to an empty queue reports not found without raising busy;
// a scan with no match ends with a final not-found result from S_FINISH.
// The timeout register is written through cfg_valid/cfg_data, always ready;
// write it only while idle. Reset empties the queue, loads the default
// timeout and clears result_valid. The receiver cannot stall results.
module pending_message_tracker #(
	parameter int unsigned DEPTH = pmt_pkg::DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  pmt_pkg::req_t              req,
	output logic                       result_valid,
	output pmt_pkg::result_t           result,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [pmt_pkg::TIME_W-1:0] cfg_data
);
	import pmt_pkg::*;

	localparam int unsigned CW = $clog2(DEPTH + 1);

	state_t            state_q, state_d;
	logic [CW-1:0]     count_q, count_d;
	logic [CW-1:0]     scan_q, scan_d;
	logic [TIME_W-1:0] timeout_q;
	logic [ID_W-1:0]   rid_q;
	logic [TIME_W-1:0] now_q;
	logic              res_valid_q, res_valid_d;
	result_t           res_q, res_d;

	logic [ID_W-1:0]   cell_id [DEPTH];
	logic [TIME_W-1:0] cell_ts [DEPTH];
	logic [ID_W-1:0]   ins_id;
	logic [TIME_W-1:0] ins_ts;

	logic accept, rec_load, rot_load, shift_all;
	logic front_match, front_old;
	logic [TIME_W-1:0] age;
	logic [CW-1:0] tail_idx;

	assign accept    = start && !busy;
	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;

	assign age         = now_q - cell_ts[0];
	assign front_match = (cell_id[0] == rid_q);
	assign front_old   = (age >= timeout_q);
	assign tail_idx    = count_q - CW'(1);

	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		scan_d      = scan_q;
		res_valid_d = 1'b0;
		res_d       = '{status: ST_NOT_FOUND, out_id: rid_q, last: 1'b1};
		rec_load    = 1'b0;
		rot_load    = 1'b0;
		shift_all   = 1'b0;
		ins_id      = req.msg_id;
		ins_ts      = req.time_ms;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					res_valid_d  = 1'b1;
					res_d.out_id = req.msg_id;
					if (req.req_type == REQ_RECORD) begin
						if (count_q == CW'(DEPTH)) begin
							res_d.status = ST_FULL;
						end else begin
							res_d.status = ST_RECORDED;
							rec_load     = 1'b1;
							count_d      = count_q + CW'(1);
						end
					end else if (count_q == '0) begin
						res_d.status = ST_NOT_FOUND;
					end else begin
						res_valid_d = 1'b0;
						scan_d      = count_q;
						state_d     = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				// take the front entry off and advance the chain
				shift_all    = 1'b1;
				scan_d       = scan_q - CW'(1);
				res_d.out_id = cell_id[0];
				if (front_match) begin
					res_valid_d  = 1'b1;
					res_d.status = ST_COMPLETED;
					count_d      = count_q - CW'(1);
					state_d      = S_IDLE;
				end else begin
					if (front_old) begin
						res_valid_d  = 1'b1;
						res_d.status = ST_EXPIRED;
						res_d.last   = 1'b0;
						count_d      = count_q - CW'(1);
					end else begin
						rot_load = 1'b1;
						ins_id   = cell_id[0];
						ins_ts   = cell_ts[0];
					end
					if (scan_q == CW'(1)) begin
						state_d = S_FINISH;
					end
				end
			end
			S_FINISH: begin
				res_valid_d = 1'b1;
				state_d     = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			scan_q      <= '0;
			timeout_q   <= TIMEOUT_RESET;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			scan_q      <= scan_d;
			res_valid_q <= res_valid_d;
			if (cfg_valid && cfg_ready) begin
				timeout_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
		if (accept && req.req_type == REQ_RESPONSE) begin
			rid_q <= req.msg_id;
			now_q <= req.time_ms;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		cell_ctrl_t        ctl;
		logic [ID_W-1:0]   nbr_id;
		logic [TIME_W-1:0] nbr_ts;

		assign ctl.load  = (rec_load && count_q == CW'(i)) ||
		                   (rot_load && tail_idx == CW'(i));
		assign ctl.shift = shift_all;

		if (i == DEPTH - 1) begin : g_end
			assign nbr_id = cell_id[i];
			assign nbr_ts = cell_ts[i];
		end else begin : g_mid
			assign nbr_id = cell_id[i+1];
			assign nbr_ts = cell_ts[i+1];
		end

		pmt_cell u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.load_id     (ins_id),
			.load_tstamp (ins_ts),
			.nbr_id      (nbr_id),
			.nbr_tstamp  (nbr_ts),
			.id          (cell_id[i]),
			.tstamp      (cell_ts[i])
		);
	end

endmodule

// ===== rtl/pmt_checker.sv =====
// Port-level assertions for the pending message tracker, bound to the top.
module pmt_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       start,
	input logic                       busy,
	input pmt_pkg::req_t              req,
	input logic                       result_valid,
	input pmt_pkg::result_t           result,
	input logic                       cfg_valid,
	input logic                       cfg_ready,
	input logic [pmt_pkg::TIME_W-1:0] cfg_data
);
	import pmt_pkg::*;

	// more words must follow a non-final result, so the block is still busy
	a_not_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last |-> busy)
		else $error("non-final result while idle");

	a_expired_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status == ST_EXPIRED |-> !result.last)
		else $error("expired result marked last");

	a_record_result: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && req.req_type == REQ_RECORD |=>
		result_valid && result.last && result.out_id == $past(req.msg_id) &&
		(result.status == ST_RECORDED || result.status == ST_FULL))
		else $error("record request without its result");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> result_valid && result.last)
		else $error("scan ended without a final result");

	// take a timeout word only while idle, and only a known one
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |-> !busy && !$isunknown(cfg_data))
		else $error("timeout written while busy or unknown");

endmodule

bind pending_message_tracker pmt_checker u_pmt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.req          (req),
	.result_valid (result_valid),
	.result       (result),
	.cfg_valid    (cfg_valid),
	.cfg_ready    (cfg_ready),
	.cfg_data     (cfg_data)
);
